### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared immediate-implication and next-cycle-implication property checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SGDLF_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sgdlf assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SGDLF_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sgdlf assertion failed");

`endif

### rtl/sgdlf_pkg.sv
// ----------------------------------------------------------------------------
// sgdlf_pkg
// Sizes, codes and helper functions of the latent factor update block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sgdlf_pkg;

   localparam int VECTOR_LEN = 20;
   localparam int ITEM_COUNT = 512;
   localparam int USER_COUNT = 2048;

   localparam int DATA_W  = 32;
   localparam int ELEM_W  = $clog2(VECTOR_LEN);
   localparam int CNT_W   = $clog2(VECTOR_LEN + 1);
   localparam int ITEM_AW = $clog2(ITEM_COUNT * VECTOR_LEN);
   localparam int USER_AW = $clog2(USER_COUNT * VECTOR_LEN);
   localparam int STEP_AW = $clog2(ITEM_COUNT);

   // Floored Q8.24 product and the dot product accumulator.
   localparam int PROD_SH_W = 40;
   localparam int ACC_W     = PROD_SH_W + CNT_W + 1;
   localparam int SAT_W     = 48;

   localparam logic [DATA_W-1:0] LR_RESET     = 32'd4294967;
   localparam logic [DATA_W-1:0] DECAY_RESET  = 32'd3865470566;
   localparam logic [DATA_W-1:0] LAMBDA_RESET = 32'd4294967;

   typedef enum logic [2:0] {
      OP_LOAD_ITEM = 3'd0,
      OP_LOAD_USER = 3'd1,
      OP_RATE      = 3'd2,
      OP_READ_ITEM = 3'd3,
      OP_READ_USER = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      CSR_LEARNING_RATE  = 2'd0,
      CSR_DECAY_RATE     = 2'd1,
      CSR_REGULARIZATION = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RD_DATA,
      ST_DOT,
      ST_ERR,
      ST_UPD,
      ST_STEP,
      ST_DONE
   } state_type;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] x);
      logic signed [SAT_W-1:0] hi;
      logic signed [SAT_W-1:0] lo;
      hi = SAT_W'(32'sh7fffffff);
      lo = -SAT_W'(64'sh80000000);
      if (x > hi) begin
         return 32'sh7fffffff;
      end else if (x < lo) begin
         return 32'sh80000000;
      end
      return x[DATA_W-1:0];
   endfunction

endpackage

### rtl/sgdlf_ram.sv
// ----------------------------------------------------------------------------
// sgdlf_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sgdlf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/sgd_latent_factor_update.sv
// ----------------------------------------------------------------------------
// sgd_latent_factor_update
// Latent factor store with a stochastic gradient descent rate update.
// ----------------------------------------------------------------------------
// The block keeps item and user latent vectors (signed Q8.24) and a step size
// per item in three on-chip RAMs. It handles one request at a time. A rate
// request streams the two vectors through the multipliers twice, once for the
// dot product and once for the read-modify-write update pass, then scales the
// step size; the two passes run one after the other on the single read port
// of each vector RAM. The error of a rate request, or the element of a read,
// comes back as rsp_result_value; loads answer zero. A new request is taken
// while the previous response still waits on rsp_ready.
`timescale 1ns / 1ps

module sgd_latent_factor_update
   import sgdlf_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [2:0]                req_op,
   input  logic [8:0]                req_item_index,
   input  logic [10:0]               req_user_index,
   input  logic [4:0]                req_element_index,
   input  logic signed [31:0]        req_element_value,
   input  logic [7:0]                req_rating,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [31:0]        rsp_result_value,
   input  logic                      csr_we,
   input  logic [1:0]                csr_index,
   input  logic [31:0]               csr_wdata
);

`include "assert_macros.svh"

   state_type state_ff, state_in;

   op_type                   op_ff;
   logic [8:0]               item_ff;
   logic [10:0]              user_ff;
   logic [4:0]               elem_ff;
   logic signed [DATA_W-1:0] value_ff;
   logic [7:0]               rating_ff;

   logic [DATA_W-1:0] lr_ff, decay_ff, lambda_ff;

   logic [CNT_W-1:0]  iss_ff;
   logic              rd_v_ff;
   logic [ELEM_W-1:0] rd_idx_ff;

   logic signed [63:0]      prod_ff;
   logic                    a_v_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [DATA_W-1:0] e_ff;

   logic signed [63:0]       eu_ff, em_ff;
   logic signed [64:0]       lm_ff, lu_ff;
   logic signed [DATA_W-1:0] m_a_ff, u_a_ff;
   logic [ELEM_W-1:0]        a_idx_ff;

   logic                     b_v_ff;
   logic                     gm_neg_ff, gu_neg_ff;
   logic [40:0]              gm_mag_ff, gu_mag_ff;
   logic signed [DATA_W-1:0] m_b_ff, u_b_ff;
   logic [ELEM_W-1:0]        b_idx_ff;

   logic                     c_v_ff;
   logic                     gm_neg_c_ff, gu_neg_c_ff;
   logic [56:0]              gm_hi_ff, gm_lo_ff, gu_hi_ff, gu_lo_ff;
   logic signed [DATA_W-1:0] m_c_ff, u_c_ff;
   logic [ELEM_W-1:0]        c_idx_ff;

   logic                     wb_v_ff;
   logic signed [DATA_W-1:0] wb_m_ff, wb_u_ff;
   logic [ELEM_W-1:0]        wb_idx_ff;

   logic [DATA_W-1:0] s_ff;
   logic              step_rd_v_ff;
   logic [63:0]       step_prod_ff;

   logic signed [DATA_W-1:0] result_ff;
   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_value_ff;

   // RAM ports
   logic               item_we, user_we, step_we;
   logic [ITEM_AW-1:0] item_waddr, item_raddr;
   logic [USER_AW-1:0] user_waddr, user_raddr;
   logic [DATA_W-1:0]  item_wdata, user_wdata, step_wdata;
   logic [DATA_W-1:0]  item_rdata, user_rdata, step_rdata;
   logic [STEP_AW-1:0] step_addr;

   // Decode
   logic               req_accept;
   logic               item_ok, user_ok, elem_ok;
   logic               issuing, dot_done, upd_done, rsp_load;
   logic [ITEM_AW-1:0] item_base;
   logic [USER_AW-1:0] user_base;

   // Datapath next values
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  err_wide;
   logic signed [40:0]       gm_in, gu_in;
   logic [57:0]              gm_sum, gu_sum;
   logic signed [43:0]       gm_step, gu_step;
   logic signed [43:0]       m_new, u_new;

   assign req_accept = req_valid && req_ready;
   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;

   assign item_ok = (32'(item_ff) < ITEM_COUNT);
   assign user_ok = (32'(user_ff) < USER_COUNT);
   assign elem_ok = (32'(elem_ff) < VECTOR_LEN);

   assign item_base = ITEM_AW'(32'(item_ff) * VECTOR_LEN);
   assign user_base = USER_AW'(32'(user_ff) * VECTOR_LEN);
   assign step_addr = STEP_AW'(item_ff);

   assign issuing  = ((state_ff == ST_DOT) || (state_ff == ST_UPD)) &&
                     (iss_ff < CNT_W'(VECTOR_LEN));
   assign dot_done = (iss_ff == CNT_W'(VECTOR_LEN)) && !rd_v_ff && !a_v_ff;
   assign upd_done = (iss_ff == CNT_W'(VECTOR_LEN)) && !rd_v_ff && !a_v_ff &&
                     !b_v_ff && !c_v_ff && !wb_v_ff;
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            unique case (op_ff)
               OP_READ_ITEM: state_in = (item_ok && elem_ok) ? ST_RD_DATA : ST_DONE;
               OP_READ_USER: state_in = (user_ok && elem_ok) ? ST_RD_DATA : ST_DONE;
               OP_RATE:      state_in = (item_ok && user_ok) ? ST_DOT : ST_DONE;
               default:      state_in = ST_DONE;
            endcase
         end
         ST_RD_DATA: state_in = ST_DONE;
         ST_DOT: begin
            if (dot_done) begin
               state_in = ST_ERR;
            end
         end
         ST_ERR: state_in = ST_UPD;
         ST_UPD: begin
            if (upd_done) begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // RAM controls
   always_comb begin
      item_we    = wb_v_ff;
      user_we    = wb_v_ff;
      step_we    = (state_ff == ST_STEP);
      item_waddr = item_base + ITEM_AW'(wb_idx_ff);
      user_waddr = user_base + USER_AW'(wb_idx_ff);
      item_wdata = wb_m_ff;
      user_wdata = wb_u_ff;
      step_wdata = step_prod_ff[63:32];
      item_raddr = item_base + ITEM_AW'(iss_ff);
      user_raddr = user_base + USER_AW'(iss_ff);
      if (state_ff == ST_EXEC) begin
         item_waddr = item_base + ITEM_AW'(elem_ff);
         user_waddr = user_base + USER_AW'(elem_ff);
         item_raddr = item_base + ITEM_AW'(elem_ff);
         user_raddr = user_base + USER_AW'(elem_ff);
         item_wdata = value_ff;
         user_wdata = value_ff;
         step_wdata = lr_ff;
         item_we    = (op_ff == OP_LOAD_ITEM) && item_ok && elem_ok;
         user_we    = (op_ff == OP_LOAD_USER) && user_ok && elem_ok;
         step_we    = (op_ff == OP_LOAD_ITEM) && item_ok && elem_ok;
      end
   end

   sgdlf_ram #(.WIDTH(DATA_W), .DEPTH(ITEM_COUNT * VECTOR_LEN)) u_item_ram (
      .clock (clock),
      .we    (item_we),
      .waddr (item_waddr),
      .wdata (item_wdata),
      .raddr (item_raddr),
      .rdata (item_rdata)
   );

   sgdlf_ram #(.WIDTH(DATA_W), .DEPTH(USER_COUNT * VECTOR_LEN)) u_user_ram (
      .clock (clock),
      .we    (user_we),
      .waddr (user_waddr),
      .wdata (user_wdata),
      .raddr (user_raddr),
      .rdata (user_rdata)
   );

   sgdlf_ram #(.WIDTH(DATA_W), .DEPTH(ITEM_COUNT)) u_step_ram (
      .clock (clock),
      .we    (step_we),
      .waddr (step_addr),
      .wdata (step_wdata),
      .raddr (step_addr),
      .rdata (step_rdata)
   );

   // Arithmetic between pipeline registers
   always_comb begin
      acc_in   = acc_ff + ACC_W'($signed(prod_ff[63:24]));
      err_wide = acc_ff - $signed({{(ACC_W-32){1'b0}}, rating_ff, 24'd0});
      gm_in    = 41'($signed(eu_ff[63:24])) + 41'($signed(lm_ff[64:32]));
      gu_in    = 41'($signed(em_ff[63:24])) + 41'($signed(lu_ff[64:32]));
      gm_sum   = {1'b0, gm_hi_ff} + 58'(gm_lo_ff[56:16]);
      gu_sum   = {1'b0, gu_hi_ff} + 58'(gu_lo_ff[56:16]);
      gm_step  = $signed({2'b00, gm_sum[57:16]});
      gu_step  = $signed({2'b00, gu_sum[57:16]});
      if (gm_neg_c_ff) begin
         gm_step = -gm_step;
      end
      if (gu_neg_c_ff) begin
         gu_step = -gu_step;
      end
      m_new = 44'(m_c_ff) - gm_step;
      u_new = 44'(u_c_ff) - gu_step;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lr_ff        <= LR_RESET;
         decay_ff     <= DECAY_RESET;
         lambda_ff    <= LAMBDA_RESET;
         iss_ff       <= '0;
         rd_v_ff      <= 1'b0;
         a_v_ff       <= 1'b0;
         b_v_ff       <= 1'b0;
         c_v_ff       <= 1'b0;
         wb_v_ff      <= 1'b0;
         step_rd_v_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_v_ff      <= issuing;
         a_v_ff       <= rd_v_ff;
         b_v_ff       <= a_v_ff && (state_ff == ST_UPD);
         c_v_ff       <= b_v_ff;
         wb_v_ff      <= c_v_ff;
         step_rd_v_ff <= (state_ff == ST_EXEC);
         if ((state_ff == ST_EXEC) || (state_ff == ST_ERR)) begin
            iss_ff <= '0;
         end else if (issuing) begin
            iss_ff <= iss_ff + 1'b1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_LEARNING_RATE:  lr_ff     <= csr_wdata;
               CSR_DECAY_RATE:     decay_ff  <= csr_wdata;
               CSR_REGULARIZATION: lambda_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff     <= op_type'(req_op);
         item_ff   <= req_item_index;
         user_ff   <= req_user_index;
         elem_ff   <= req_element_index;
         value_ff  <= req_element_value;
         rating_ff <= req_rating;
      end

      rd_idx_ff <= iss_ff[ELEM_W-1:0];

      // Stage A: every product of the element pair.
      prod_ff  <= $signed(item_rdata) * $signed(user_rdata);
      eu_ff    <= e_ff * $signed(user_rdata);
      em_ff    <= e_ff * $signed(item_rdata);
      lm_ff    <= $signed({1'b0, lambda_ff}) * $signed(item_rdata);
      lu_ff    <= $signed({1'b0, lambda_ff}) * $signed(user_rdata);
      m_a_ff   <= item_rdata;
      u_a_ff   <= user_rdata;
      a_idx_ff <= rd_idx_ff;

      if (state_ff == ST_EXEC) begin
         acc_ff <= '0;
      end else if (a_v_ff && (state_ff == ST_DOT)) begin
         acc_ff <= acc_in;
      end

      // Stage B: gradients as sign and magnitude.
      gm_neg_ff <= gm_in[40];
      gu_neg_ff <= gu_in[40];
      gm_mag_ff <= gm_in[40] ? 41'(-gm_in) : 41'(gm_in);
      gu_mag_ff <= gu_in[40] ? 41'(-gu_in) : 41'(gu_in);
      m_b_ff    <= m_a_ff;
      u_b_ff    <= u_a_ff;
      b_idx_ff  <= a_idx_ff;

      // Stage C: magnitude times step, split in two 16-bit halves of the step.
      gm_hi_ff    <= gm_mag_ff * s_ff[31:16];
      gm_lo_ff    <= gm_mag_ff * s_ff[15:0];
      gu_hi_ff    <= gu_mag_ff * s_ff[31:16];
      gu_lo_ff    <= gu_mag_ff * s_ff[15:0];
      gm_neg_c_ff <= gm_neg_ff;
      gu_neg_c_ff <= gu_neg_ff;
      m_c_ff      <= m_b_ff;
      u_c_ff      <= u_b_ff;
      c_idx_ff    <= b_idx_ff;

      // Stage D: new elements, written back the next cycle.
      wb_m_ff   <= sat32(SAT_W'(m_new));
      wb_u_ff   <= sat32(SAT_W'(u_new));
      wb_idx_ff <= c_idx_ff;

      if (step_rd_v_ff) begin
         s_ff <= step_rdata;
      end
      step_prod_ff <= s_ff * decay_ff;

      if (state_ff == ST_ERR) begin
         e_ff <= sat32(SAT_W'(err_wide));
      end

      unique case (state_ff)
         ST_EXEC:    result_ff <= '0;
         ST_RD_DATA: result_ff <= (op_ff == OP_READ_ITEM) ? item_rdata : user_rdata;
         ST_ERR:     result_ff <= sat32(SAT_W'(err_wide));
         default:    result_ff <= result_ff;
      endcase

      if (rsp_load) begin
         rsp_value_ff <= result_ff;
      end
   end

   // The dot product pass only reads; no element may be written under it.
   `SGDLF_ASSERT_IMP(a_no_write_in_dot, clock, reset, state_ff == ST_DOT, !item_we && !user_we)
   // Every accepted request is decoded in the following cycle.
   `SGDLF_ASSERT_NXT(a_accept_to_exec, clock, reset, req_accept, state_ff == ST_EXEC)
   // The step is scaled only after the update pipeline has drained.
   `SGDLF_ASSERT_IMP(a_step_after_drain, clock, reset, state_ff == ST_STEP, !wb_v_ff && !c_v_ff)
   // A response appears only when a request has completed.
   `SGDLF_ASSERT_IMP(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff == ST_DONE))

endmodule

### verif/tb_sgd_latent_factor_update.sv
// ----------------------------------------------------------------------------
// Latent factor update testbench
// Loads a pool of item and user vectors, runs a directed table of requests
// and then random request streams under four handshake idling phases and
// several register settings. Each response is checked against its typed row
// or a local predictor of the stores, step sizes and rate update arithmetic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sgd_latent_factor_update;
   import sgdlf_pkg::*;

   localparam int POOL_SIZE  = 8;
   localparam int RAND_ITEMS = 190;
   localparam int SETTLE     = 80;

   typedef struct {
      op_type           op;
      logic [8:0]       item;
      logic [10:0]      user;
      logic [4:0]       elem;
      logic [31:0]      value;
      logic [7:0]       rating;
      bit               typed;
      logic [31:0]      expected;
   } request_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_op;
   logic [8:0]  req_item_index;
   logic [10:0] req_user_index;
   logic [4:0]  req_element_index;
   logic signed [31:0] req_element_value;
   logic [7:0]  req_rating;
   logic        rsp_valid;
   logic        rsp_ready;
   logic signed [31:0] rsp_result_value;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;

   // Typed expectation travels with the payload of a directed request.
   bit          drv_typed;
   logic [31:0] drv_expected;

   logic signed [31:0] item_store [ITEM_COUNT*VECTOR_LEN];
   logic signed [31:0] user_store [USER_COUNT*VECTOR_LEN];
   logic [31:0]        step_store [ITEM_COUNT];
   logic [31:0]        cur_learning_rate;
   logic [31:0]        cur_decay;
   logic [31:0]        cur_lambda;

   logic [31:0] expected_results [$];
   int          mismatches;
   int          responses;
   int          rate_requests;
   int          sender_idle_pct;
   int          receiver_stall_pct;
   int          hold_request;
   int          hold_left;
   logic [8:0]  item_pool [POOL_SIZE];
   logic [10:0] user_pool [POOL_SIZE];
   logic [8:0]  last_rand_item;
   logic [4:0]  last_rand_elem;
   bit          rand_item_loaded;

   sgd_latent_factor_update i_dut (.*);

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic logic signed [31:0] saturate_word(longint x);
      if (x > 64'sd2147483647) return 32'sh7fffffff;
      if (x < -64'sd2147483648) return 32'sh80000000;
      return x[31:0];
   endfunction

   // Product of a gradient and a Q0.32 step, truncated toward zero.
   function automatic longint step_term(longint g, logic [31:0] s);
      logic [95:0] prod;
      logic [63:0] mag;
      longint      r;
      mag  = (g < 0) ? -g : g;
      prod = {32'b0, mag} * {64'b0, s};
      r    = longint'(prod[95:32]);
      return (g < 0) ? -r : r;
   endfunction

   function automatic logic [31:0] predict_request(logic [2:0] op, logic [8:0] item,
                                                   logic [10:0] user, logic [4:0] elem,
                                                   logic signed [31:0] value,
                                                   logic [7:0] rating);
      int      ib;
      int      ub;
      longint  acc;
      longint  err;
      longint  m0;
      longint  u0;
      longint  lam;
      longint  gm;
      longint  gu;
      logic [63:0] step_prod;
      logic signed [31:0] result;
      ib     = item * VECTOR_LEN;
      ub     = user * VECTOR_LEN;
      result = '0;
      lam    = longint'({32'b0, cur_lambda});
      if (op == OP_LOAD_ITEM && elem < VECTOR_LEN) begin
         item_store[ib + elem] = value;
         step_store[item] = cur_learning_rate;
      end else if (op == OP_LOAD_USER && elem < VECTOR_LEN) begin
         user_store[ub + elem] = value;
      end else if (op == OP_READ_ITEM && elem < VECTOR_LEN) begin
         result = item_store[ib + elem];
      end else if (op == OP_READ_USER && elem < VECTOR_LEN) begin
         result = user_store[ub + elem];
      end else if (op == OP_RATE) begin
         acc = 0;
         for (int i = 0; i < VECTOR_LEN; i++) begin
            acc += (longint'(item_store[ib + i]) * longint'(user_store[ub + i])) >>> 24;
         end
         acc -= longint'(rating) * 64'sd16777216;
         result = saturate_word(acc);
         err = longint'(result);
         for (int i = 0; i < VECTOR_LEN; i++) begin
            m0 = longint'(item_store[ib + i]);
            u0 = longint'(user_store[ub + i]);
            gm = ((err * u0) >>> 24) + ((lam * m0) >>> 32);
            gu = ((err * m0) >>> 24) + ((lam * u0) >>> 32);
            item_store[ib + i] = saturate_word(m0 - step_term(gm, step_store[item]));
            user_store[ub + i] = saturate_word(u0 - step_term(gu, step_store[item]));
         end
         step_prod = {32'b0, step_store[item]} * {32'b0, cur_decay};
         step_store[item] = step_prod[63:32];
      end
      return result;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   // Expectations are formed when a request is accepted.
   always @(posedge clock) begin
      logic [31:0] predicted;
      if (!reset && req_valid && req_ready) begin
         predicted = predict_request(req_op, req_item_index, req_user_index,
                                     req_element_index, req_element_value, req_rating);
         if (req_op == OP_RATE) rate_requests++;
         expected_results.push_back(drv_typed ? drv_expected : predicted);
      end
   end

   always @(posedge clock) begin
      logic [31:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         responses++;
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected response", rsp_result_value, 'x);
         end else begin
            want = expected_results.pop_front();
            if (rsp_result_value !== want) begin
               report_mismatch("result_value", rsp_result_value, want);
            end
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else if (hold_request != 0) begin
         hold_request = 0;
         hold_left <= 400;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   task automatic send_request(request_row_type row);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_op            <= row.op;
      req_item_index    <= row.item;
      req_user_index    <= row.user;
      req_element_index <= row.elem;
      req_element_value <= row.value;
      req_rating        <= row.rating;
      drv_typed         <= row.typed;
      drv_expected      <= row.expected;
      do begin
         @(posedge clock);
      end while (!req_ready);
   endtask

   task automatic send_op(logic [2:0] op, logic [8:0] item, logic [10:0] user,
                          logic [4:0] elem, logic [31:0] value, logic [7:0] rating);
      request_row_type row;
      row = '{op_type'(op), item, user, elem, value, rating, 1'b0, '0};
      send_request(row);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_LEARNING_RATE: begin
            cur_learning_rate = value;
         end
         CSR_DECAY_RATE: begin
            cur_decay = value;
         end
         default: begin
            cur_lambda = value;
         end
      endcase
   endtask

   function automatic logic [31:0] random_value();
      case ($urandom_range(3))
         0: return $urandom();
         1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
         default: return 32'($signed($urandom_range(67108864)) - 33554432);
      endcase
   endfunction

   task automatic random_request();
      int          pick;
      int          slot;
      logic [4:0]  elem;
      logic [8:0]  item;
      logic [2:0]  bad_op;
      pick = $urandom_range(99);
      slot = $urandom_range(POOL_SIZE - 1);
      elem = 5'($urandom_range(VECTOR_LEN - 1));
      if (pick < 40) begin
         send_op(OP_RATE, item_pool[slot], user_pool[$urandom_range(POOL_SIZE - 1)],
                 5'($urandom()), $urandom(), 8'($urandom()));
      end else if (pick < 50) begin
         send_op(OP_LOAD_ITEM, item_pool[slot], 11'($urandom()), elem, random_value(),
                 8'($urandom()));
      end else if (pick < 58) begin
         send_op(OP_LOAD_USER, 9'($urandom()), user_pool[slot], elem, random_value(),
                 8'($urandom()));
      end else if (pick < 74) begin
         send_op($urandom_range(1) ? OP_READ_ITEM : OP_READ_USER, item_pool[slot],
                 user_pool[$urandom_range(POOL_SIZE - 1)], elem, $urandom(), 8'($urandom()));
      end else if (pick < 84) begin
         // Loads anywhere in the stores; the last item load is read back later.
         item = 9'($urandom());
         if ($urandom_range(1)) begin
            send_op(OP_LOAD_ITEM, item, 11'($urandom()), elem, random_value(), 8'($urandom()));
            last_rand_item   = item;
            last_rand_elem   = elem;
            rand_item_loaded = 1;
         end else begin
            send_op(OP_LOAD_USER, item, 11'($urandom()), elem, random_value(), 8'($urandom()));
         end
      end else if (pick < 90 && rand_item_loaded) begin
         send_op(OP_READ_ITEM, last_rand_item, 11'($urandom()), last_rand_elem, $urandom(),
                 8'($urandom()));
      end else if (pick < 95) begin
         // Element index past the vector end: loads are dropped and reads return zero.
         bad_op = 3'($urandom_range(4));
         if (bad_op == OP_RATE) bad_op = OP_READ_USER;
         send_op(bad_op, 9'($urandom()), 11'($urandom()), 5'($urandom_range(31, VECTOR_LEN)),
                 $urandom(), 8'($urandom()));
      end else begin
         send_op(3'($urandom_range(7, 5)), 9'($urandom()), 11'($urandom()),
                 5'($urandom()), $urandom(), 8'($urandom()));
      end
   endtask

   request_row_type directed_table [] = '{
      '{OP_LOAD_ITEM, 9'd511, 11'd0,    5'd19, 32'h7fffffff, 8'd0,   1'b1, 32'h0},
      '{OP_READ_ITEM, 9'd511, 11'd0,    5'd19, 32'h0,        8'd0,   1'b1, 32'h7fffffff},
      '{OP_LOAD_USER, 9'd0,   11'd2047, 5'd0,  32'h80000000, 8'd0,   1'b1, 32'h0},
      '{OP_READ_USER, 9'd0,   11'd2047, 5'd0,  32'h0,        8'd0,   1'b1, 32'h80000000},
      '{OP_READ_ITEM, 9'd0,   11'd0,    5'd20, 32'h0,        8'd0,   1'b1, 32'h0},
      '{OP_READ_USER, 9'd0,   11'd0,    5'd31, 32'h0,        8'd0,   1'b1, 32'h0},
      '{OP_LOAD_ITEM, 9'd0,   11'd0,    5'd31, 32'h5,        8'd0,   1'b1, 32'h0},
      '{op_type'(5),  9'd1,   11'd1,    5'd1,  32'hffffffff, 8'd255, 1'b1, 32'h0},
      '{op_type'(6),  9'd2,   11'd2,    5'd2,  32'h1,        8'd1,   1'b1, 32'h0},
      '{op_type'(7),  9'd511, 11'd2047, 5'd31, 32'h80000000, 8'd128, 1'b1, 32'h0},
      '{OP_RATE,      9'd511, 11'd2047, 5'd0,  32'h0,        8'd0,   1'b0, 32'h0},
      '{OP_RATE,      9'd511, 11'd2047, 5'd31, 32'h0,        8'd255, 1'b0, 32'h0},
      '{OP_RATE,      9'd0,   11'd0,    5'd0,  32'h0,        8'd255, 1'b0, 32'h0},
      '{OP_RATE,      9'd0,   11'd0,    5'd0,  32'h0,        8'd0,   1'b0, 32'h0},
      '{OP_READ_ITEM, 9'd0,   11'd0,    5'd3,  32'h0,        8'd0,   1'b0, 32'h0},
      '{OP_READ_USER, 9'd0,   11'd0,    5'd3,  32'h0,        8'd0,   1'b0, 32'h0},
      '{OP_LOAD_USER, 9'd0,   11'd5,    5'd4,  32'h0,        8'd0,   1'b1, 32'h0},
      '{OP_RATE,      9'd5,   11'd5,    5'd0,  32'h0,        8'd3,   1'b0, 32'h0}
   };

   initial begin
      #20ms;
      $display("Timeout with %0d results outstanding", expected_results.size());
      $display("Some tests failed");
      $finish;
   end

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_op            = '0;
      req_item_index    = '0;
      req_user_index    = '0;
      req_element_index = '0;
      req_element_value = '0;
      req_rating        = '0;
      csr_we            = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      drv_typed         = 1'b0;
      drv_expected      = '0;
      mismatches        = 0;
      responses         = 0;
      rate_requests     = 0;
      hold_request      = 0;
      rand_item_loaded  = 0;
      sender_idle_pct   = 0;
      receiver_stall_pct = 0;
      cur_learning_rate = LR_RESET;
      cur_decay         = DECAY_RESET;
      cur_lambda        = LAMBDA_RESET;
      item_pool = '{9'd0, 9'd1, 9'd2, 9'd3, 9'd4, 9'd5, 9'd6, 9'd511};
      user_pool = '{11'd0, 11'd1, 11'd2, 11'd3, 11'd4, 11'd5, 11'd6, 11'd2047};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fill the working vectors so every later read or rate hits written data.
      for (int p = 0; p < POOL_SIZE; p++) begin
         for (int e = 0; e < VECTOR_LEN; e++) begin
            send_op(OP_LOAD_ITEM, item_pool[p], 11'($urandom()), 5'(e),
                    (p == POOL_SIZE - 1) ? 32'h7fffffff : random_value(), 8'($urandom()));
            send_op(OP_LOAD_USER, 9'($urandom()), user_pool[p], 5'(e),
                    (p == POOL_SIZE - 1) ? 32'h7fffffff : random_value(), 8'($urandom()));
         end
      end

      foreach (directed_table[r]) send_request(directed_table[r]);
      drv_typed <= 1'b0;

      for (int phase = 0; phase < 4; phase++) begin
         wait_idle();
         case (phase)
            0: begin
               write_csr(CSR_LEARNING_RATE, 32'hffffffff);
               write_csr(CSR_DECAY_RATE, 32'hffffffff);
               write_csr(CSR_REGULARIZATION, 32'h0);
               sender_idle_pct = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               write_csr(CSR_LEARNING_RATE, 32'h0);
               write_csr(CSR_DECAY_RATE, 32'h0);
               write_csr(CSR_REGULARIZATION, 32'hffffffff);
               sender_idle_pct = 45;
               receiver_stall_pct = 0;
            end
            2: begin
               write_csr(CSR_LEARNING_RATE, $urandom());
               write_csr(CSR_DECAY_RATE, $urandom());
               write_csr(CSR_REGULARIZATION, $urandom());
               sender_idle_pct = 0;
               receiver_stall_pct = 45;
               // Long receiver hold-off while requests keep coming.
               hold_request = 1;
            end
            default: begin
               write_csr(CSR_LEARNING_RATE, LR_RESET);
               write_csr(CSR_DECAY_RATE, DECAY_RESET);
               write_csr(CSR_REGULARIZATION, LAMBDA_RESET);
               sender_idle_pct = 34;
               receiver_stall_pct = 34;
            end
         endcase
         for (int n = 0; n < RAND_ITEMS; n++) random_request();
      end

      wait_idle();
      $display("Checked %0d responses, %0d of them rate updates, over four idling phases",
               responses, rate_requests);
      $display("and four register settings including all-zero and all-one values.");
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### sgd_latent_factor_update.f
+incdir+rtl
rtl/sgdlf_pkg.sv
rtl/sgdlf_ram.sv
rtl/sgd_latent_factor_update.sv
verif/tb_sgd_latent_factor_update.sv
